// ===== rtl/glrp_pkg.sv =====
// ----------------------------------------------------------------------------
// glrp_pkg
// Shared widths and sequencer state codes for the load rebalance planner.
// ----------------------------------------------------------------------------
package glrp_pkg;

  // Fixed field widths of the load and move channels
  localparam int unsigned ID_W   = 4;
  localparam int unsigned DATA_W = 32;

  // Planner sequencer states, one-hot
  typedef enum logic [9:0] {
    S_LOAD  = 10'b00_0000_0001,  // taking load transfers
    S_SUM   = 10'b00_0000_0010,  // sum present counts, one entry a cycle
    S_DIV   = 10'b00_0000_0100,  // restoring divide, one quotient bit a cycle
    S_CLASS = 10'b00_0000_1000,  // mark sources and sinks
    S_SINK  = 10'b00_0001_0000,  // scan for the smallest pending sink
    S_PICK  = 10'b00_0010_0000,  // take the sink found by the scan
    S_CHK   = 10'b00_0100_0000,  // sink full yet?
    S_SRC   = 10'b00_1000_0000,  // scan for the largest active source
    S_CALC  = 10'b01_0000_0000,  // source surplus and sink shortfall
    S_MOVE  = 10'b10_0000_0000   // commit one move
  } glrp_state_e;

  // End of plan: after the held move or the empty marker is flushed, back to S_LOAD
  localparam glrp_state_e S_DONE_CODE = S_LOAD;

  typedef struct packed {
    logic [ID_W-1:0]   src;
    logic [ID_W-1:0]   dst;
    logic [DATA_W-1:0] amt;
  } glrp_move_t;

endpackage

// ===== rtl/greedy_load_rebalance_planner.sv =====
// ----------------------------------------------------------------------------
// greedy_load_rebalance_planner
// Loads per-worker object counts, then plans greedy moves that bring every
// sink up to the floor average, drawing from the fullest sources first.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  load    | in        | in_valid_i / in_ready_o | worker_id_i, object_count_i,
//          |           |                         | last_worker_i
//  move    | out       | out_valid_o/out_ready_i | source_worker_o, dest_worker_o,
//          |           |                         | move_amount_o, plan_empty_o,
//          |           |                         | last_move_o
//
//  A last load starts a plan. The count table is walked one entry per cycle
//  through one shared read index, and the average comes from a
//  one-bit-per-cycle divider.
//  Each move is held one step so that the final one can carry last_move.
//  Reset is asynchronous, active low, and empties the loaded set.
//  A stalled move output holds the sequencer in its move step until the
//  output register frees.
// ----------------------------------------------------------------------------
module greedy_load_rebalance_planner
  import glrp_pkg::*;
#(
  parameter int unsigned WORKERS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ID_W-1:0]   worker_id_i,
  input  logic [DATA_W-1:0] object_count_i,
  input  logic              last_worker_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ID_W-1:0]   source_worker_o,
  output logic [ID_W-1:0]   dest_worker_o,
  output logic [DATA_W-1:0] move_amount_o,
  output logic              plan_empty_o,
  output logic              last_move_o
);

  localparam int unsigned IDX_W  = $clog2(WORKERS);
  localparam int unsigned LD_W   = $clog2(WORKERS + 1);
  localparam int unsigned SUM_W  = DATA_W + $clog2(WORKERS);
  localparam int unsigned DCNT_W = $clog2(SUM_W);

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WORKERS - 1);
  localparam logic [DCNT_W-1:0] LAST_BIT = DCNT_W'(SUM_W - 1);

  // Control state
  glrp_state_e        state_q, state_d;
  logic [WORKERS-1:0] present_q, present_d;
  logic [WORKERS-1:0] src_act_q, src_act_d;
  logic [WORKERS-1:0] sink_pend_q, sink_pend_d;
  logic [LD_W-1:0]    loaded_q, loaded_d;
  logic               hold_valid_q, hold_valid_d;
  logic               out_valid_q, out_valid_d;

  // Datapath registers
  logic [DATA_W-1:0]  count_q [WORKERS];
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [SUM_W-1:0]   quot_q, quot_d;
  logic [LD_W-1:0]    rem_q, rem_d;
  logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               found_q, found_d;
  logic               any_q, any_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [DATA_W-1:0]  best_val_q, best_val_d;
  logic [DATA_W-1:0]  have_q, have_d;
  logic [IDX_W-1:0]   sink_q, sink_d;
  logic [IDX_W-1:0]   src_q, src_d;
  logic [DATA_W-1:0]  can_q, can_d;
  logic [DATA_W-1:0]  need_q, need_d;
  glrp_move_t         hold_q, hold_d;
  glrp_move_t         out_q, out_d;
  logic               out_empty_q, out_empty_d;
  logic               out_last_q, out_last_d;

  // Table write port
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_waddr;
  logic [DATA_W-1:0]  cnt_wdata;

  // Shared scan and divide datapath
  logic [DATA_W-1:0]  avg;
  logic [DATA_W-1:0]  cur_cnt;
  logic               last_idx;
  logic               in_range;
  logic [IDX_W-1:0]   load_idx;
  logic [LD_W:0]      trial;
  logic               trial_ge;
  logic               out_free;
  logic               take_can;
  logic [DATA_W-1:0]  amt;

  assign avg      = quot_q[DATA_W-1:0];
  assign cur_cnt  = count_q[idx_q];
  assign last_idx = (idx_q == LAST_IDX);
  assign in_range = (32'(worker_id_i) < WORKERS);
  assign load_idx = IDX_W'(worker_id_i);
  assign trial    = {rem_q, quot_q[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, loaded_q});
  assign out_free = !out_valid_q || out_ready_i;
  assign take_can = (need_q >= can_q);
  assign amt      = take_can ? can_q : need_q;

  // Sequencer and next-state logic
  always_comb begin
    state_d      = state_q;
    present_d    = present_q;
    src_act_d    = src_act_q;
    sink_pend_d  = sink_pend_q;
    loaded_d     = loaded_q;
    hold_valid_d = hold_valid_q;
    sum_d        = sum_q;
    quot_d       = quot_q;
    rem_d        = rem_q;
    dcnt_d       = dcnt_q;
    idx_d        = idx_q;
    found_d      = found_q;
    any_d        = any_q;
    best_idx_d   = best_idx_q;
    best_val_d   = best_val_q;
    have_d       = have_q;
    sink_d       = sink_q;
    src_d        = src_q;
    can_d        = can_q;
    need_d       = need_q;
    hold_d       = hold_q;
    out_d        = out_q;
    out_empty_d  = out_empty_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cnt_we       = 1'b0;
    cnt_waddr    = load_idx;
    cnt_wdata    = object_count_i;

    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (in_range) begin
            cnt_we = 1'b1;
            if (!present_q[load_idx]) begin
              present_d[load_idx] = 1'b1;
              loaded_d            = loaded_q + LD_W'(1);
            end
          end
          if (last_worker_i) begin
            idx_d = '0;
            sum_d = '0;
            if (loaded_d == '0) begin
              state_d = S_MOVE;
            end else begin
              state_d = S_SUM;
            end
          end
        end
      end

      S_SUM: begin
        if (present_q[idx_q]) begin
          sum_d = sum_q + SUM_W'(cur_cnt);
        end
        if (last_idx) begin
          quot_d  = sum_d;
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = S_DIV;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      // Restoring divide: quotient bits shift in behind the dividend
      S_DIV: begin
        rem_d  = trial_ge ? LD_W'(trial - {1'b0, loaded_q}) : trial[LD_W-1:0];
        quot_d = {quot_q[SUM_W-2:0], trial_ge};
        if (dcnt_q == LAST_BIT) begin
          idx_d   = '0;
          state_d = S_CLASS;
        end else begin
          dcnt_d = dcnt_q + DCNT_W'(1);
        end
      end

      S_CLASS: begin
        src_act_d[idx_q]   = present_q[idx_q] && (cur_cnt > avg);
        sink_pend_d[idx_q] = present_q[idx_q] && !(cur_cnt > avg);
        if (last_idx) begin
          idx_d   = '0;
          found_d = 1'b0;
          any_d   = 1'b0;
          state_d = S_SINK;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      // Smallest pending sink; strict compare keeps the lowest id on ties
      S_SINK: begin
        any_d = any_q || src_act_q[idx_q];
        if (sink_pend_q[idx_q] && (!found_q || cur_cnt < best_val_q)) begin
          found_d    = 1'b1;
          best_idx_d = idx_q;
          best_val_d = cur_cnt;
        end
        if (last_idx) begin
          state_d = S_PICK;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_PICK: begin
        if (found_q && any_q) begin
          sink_pend_d[best_idx_q] = 1'b0;
          sink_d                  = best_idx_q;
          have_d                  = best_val_q;
          state_d                 = S_CHK;
        end else begin
          state_d = S_MOVE;
        end
      end

      S_CHK: begin
        idx_d   = '0;
        found_d = 1'b0;
        any_d   = 1'b0;
        if (have_q < avg) begin
          state_d = S_SRC;
        end else begin
          state_d = S_SINK;
        end
      end

      // Largest remaining source, lowest id on ties
      S_SRC: begin
        if (src_act_q[idx_q] && (!found_q || cur_cnt > best_val_q)) begin
          found_d    = 1'b1;
          best_idx_d = idx_q;
          best_val_d = cur_cnt;
        end
        if (last_idx) begin
          state_d = S_CALC;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_CALC: begin
        if (found_q) begin
          src_d   = best_idx_q;
          can_d   = best_val_q - avg;
          need_d  = avg - have_q;
          state_d = S_MOVE;
        end else begin
          idx_d   = '0;
          found_d = 1'b0;
          any_d   = 1'b0;
          state_d = S_SINK;
        end
      end

      // S_MOVE with a live sink commits one move; reached from S_LOAD or
      // S_PICK with the plan over, it flushes the last result instead.
      S_MOVE: begin
        if (out_free) begin
          if (found_q && have_q < avg && src_act_q[src_q] &&
              !(sink_pend_q[sink_q])) begin
            // A source that hands over its whole surplus retires
            if (take_can) begin
              src_act_d[src_q] = 1'b0;
            end
            cnt_we    = 1'b1;
            cnt_waddr = src_q;
            cnt_wdata = best_val_q - amt;
            have_d    = have_q + amt;
            if (hold_valid_q) begin
              out_d       = hold_q;
              out_empty_d = 1'b0;
              out_last_d  = 1'b0;
              out_valid_d = 1'b1;
            end
            hold_d.src   = ID_W'(src_q);
            hold_d.dst   = ID_W'(sink_q);
            hold_d.amt   = amt;
            hold_valid_d = 1'b1;
            state_d      = S_CHK;
          end else begin
            if (hold_valid_q) begin
              out_d       = hold_q;
              out_empty_d = 1'b0;
            end else begin
              out_d       = '0;
              out_empty_d = 1'b1;
            end
            out_last_d   = 1'b1;
            out_valid_d  = 1'b1;
            hold_valid_d = 1'b0;
            present_d    = '0;
            src_act_d    = '0;
            sink_pend_d  = '0;
            loaded_d     = '0;
            sum_d        = '0;
            found_d      = 1'b0;
            state_d      = S_DONE_CODE;
          end
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      present_q    <= '0;
      src_act_q    <= '0;
      sink_pend_q  <= '0;
      loaded_q     <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      sum_q        <= '0;
      found_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      present_q    <= present_d;
      src_act_q    <= src_act_d;
      sink_pend_q  <= sink_pend_d;
      loaded_q     <= loaded_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
      sum_q        <= sum_d;
      found_q      <= found_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quot_q      <= quot_d;
    rem_q       <= rem_d;
    dcnt_q      <= dcnt_d;
    idx_q       <= idx_d;
    any_q       <= any_d;
    best_idx_q  <= best_idx_d;
    best_val_q  <= best_val_d;
    have_q      <= have_d;
    sink_q      <= sink_d;
    src_q       <= src_d;
    can_q       <= can_d;
    need_q      <= need_d;
    hold_q      <= hold_d;
    out_q       <= out_d;
    out_empty_q <= out_empty_d;
    out_last_q  <= out_last_d;
  end

  // Count table: loads and source remainders share one write port
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      count_q[cnt_waddr] <= cnt_wdata;
    end
  end

  assign in_ready_o      = (state_q == S_LOAD);
  assign out_valid_o     = out_valid_q;
  assign source_worker_o = out_q.src;
  assign dest_worker_o   = out_q.dst;
  assign move_amount_o   = out_q.amt;
  assign plan_empty_o    = out_empty_q;
  assign last_move_o     = out_last_q;

`ifndef SYNTHESIS
  // The empty marker always closes its plan and carries no move
  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> out_last_q && out_q.amt == '0 &&
    out_q.src == '0 && out_q.dst == '0)
    else $error("empty-plan marker malformed");

  // Every real move carries objects between two distinct workers
  a_move_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_empty_q |-> out_q.amt != '0 && out_q.src != out_q.dst)
    else $error("degenerate move emitted");

  // No move is left held once the planner is back to loading
  a_hold_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> !hold_valid_q)
    else $error("held move not flushed at end of plan");

  // A sink never overshoots the average
  a_sink_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> have_q <= avg)
    else $error("sink filled beyond the average");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for greedy_load_rebalance_planner. Count sets are
// loaded over the load channel. A built-in planner works out the greedy move
// list for each set, and every move transfer is checked field by field
// against it. Directed sets cover the extremes first. Random sets follow
// under four idle/stall phases.
// ----------------------------------------------------------------------------
module tb
  import glrp_pkg::*;
();

  localparam int unsigned NWORK      = 16;
  localparam int unsigned PLAN_CAP   = 32;
  localparam int unsigned STALL_LIMIT = 20000;

  // How the counts of one random set are spread
  typedef enum logic [1:0] {
    SPREAD_SMALL,
    SPREAD_FULL,
    SPREAD_TOP,
    SPREAD_MIXED
  } spread_e;

  typedef struct packed {
    logic [ID_W-1:0]   src;
    logic [ID_W-1:0]   dst;
    logic [DATA_W-1:0] amt;
    logic              empty;
    logic              last;
  } move_exp_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [ID_W-1:0]   worker_id_i    = '0;
  logic [DATA_W-1:0] object_count_i = '0;
  logic              last_worker_i  = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [ID_W-1:0]   source_worker_o;
  logic [ID_W-1:0]   dest_worker_o;
  logic [DATA_W-1:0] move_amount_o;
  logic              plan_empty_o;
  logic              last_move_o;

  // Planner copy of the loaded set
  logic [DATA_W-1:0] cnt_tbl [NWORK];
  bit                seen    [NWORK];
  logic [63:0]       tally;
  int unsigned       n_loaded;

  move_exp_t         pending_moves [$];
  move_exp_t         want_mv;
  int unsigned       fail_cnt;
  int unsigned       src_idle_pct;
  int unsigned       stall_pct;
  int unsigned       quiet_cyc = 0;

  greedy_load_rebalance_planner #(
    .WORKERS(NWORK)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .worker_id_i    (worker_id_i),
    .object_count_i (object_count_i),
    .last_worker_i  (last_worker_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .source_worker_o(source_worker_o),
    .dest_worker_o  (dest_worker_o),
    .move_amount_o  (move_amount_o),
    .plan_empty_o   (plan_empty_o),
    .last_move_o    (last_move_o)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Greedy planner: fill the emptiest sinks from the fullest sources
  // --------------------------------------------------------------------------
  function automatic void plan_moves();
    logic [63:0] remain   [NWORK];
    bit          src_on   [NWORK];
    bit          snk_wait [NWORK];
    logic [63:0] avg, have, can, need, amt;
    int          sink, src;
    bit          any_src;
    move_exp_t   plan_q [$];
    move_exp_t   mv;
    if (n_loaded != 0) begin
      avg = tally / 64'(n_loaded);
      for (int i = 0; i < NWORK; i++) begin
        remain[i]   = 64'(cnt_tbl[i]);
        src_on[i]   = seen[i] && (64'(cnt_tbl[i]) > avg);
        snk_wait[i] = seen[i] && (64'(cnt_tbl[i]) <= avg);
      end
      forever begin
        // smallest pending sink, lowest id on ties
        sink    = -1;
        any_src = 1'b0;
        for (int i = 0; i < NWORK; i++) begin
          if (src_on[i]) any_src = 1'b1;
          if (snk_wait[i] && (sink < 0 || cnt_tbl[i] < cnt_tbl[sink])) sink = i;
        end
        if (sink < 0 || !any_src) break;
        snk_wait[sink] = 1'b0;
        have = 64'(cnt_tbl[sink]);
        while (have < avg && plan_q.size() < PLAN_CAP) begin
          // fullest remaining source, lowest id on ties
          src = -1;
          for (int i = 0; i < NWORK; i++) begin
            if (src_on[i] && (src < 0 || remain[i] > remain[src])) src = i;
          end
          if (src < 0) break;
          can  = remain[src] - avg;
          need = avg - have;
          if (need >= can) begin
            amt         = can;
            src_on[src] = 1'b0;
          end else begin
            amt = need;
            if (remain[src] - amt < avg + 1) src_on[src] = 1'b0;
          end
          remain[src] -= amt;
          have        += amt;
          mv     = '0;
          mv.src = src[ID_W-1:0];
          mv.dst = sink[ID_W-1:0];
          mv.amt = amt[DATA_W-1:0];
          plan_q.push_back(mv);
        end
        if (plan_q.size() >= PLAN_CAP) break;
      end
    end
    // nothing to move: a single empty-plan marker
    if (plan_q.size() == 0) begin
      mv       = '0;
      mv.empty = 1'b1;
      plan_q.push_back(mv);
    end
    mv      = plan_q.pop_back();
    mv.last = 1'b1;
    plan_q.push_back(mv);
    foreach (plan_q[k]) pending_moves.push_back(plan_q[k]);
  endfunction

  // Record one accepted load; the last one of a set triggers planning
  function automatic void load_count(logic [ID_W-1:0] id, logic [DATA_W-1:0] cnt,
                                     logic last);
    if (seen[id]) begin
      tally -= 64'(cnt_tbl[id]);
    end else begin
      seen[id] = 1'b1;
      n_loaded++;
    end
    cnt_tbl[id] = cnt;
    tally      += 64'(cnt);
    if (last) begin
      plan_moves();
      foreach (seen[i]) seen[i] = 1'b0;
      tally    = '0;
      n_loaded = 0;
    end
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Move channel: check each transfer, stall at random
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_moves.size() == 0) begin
        $error("move transfer with none pending: src %0d dst %0d amount 0x%0h",
               source_worker_o, dest_worker_o, move_amount_o);
        fail_cnt++;
      end else begin
        want_mv = pending_moves.pop_front();
        check_field("source_worker", DATA_W'(want_mv.src), DATA_W'(source_worker_o));
        check_field("dest_worker", DATA_W'(want_mv.dst), DATA_W'(dest_worker_o));
        check_field("move_amount", want_mv.amt, move_amount_o);
        check_field("plan_empty", DATA_W'(want_mv.empty), DATA_W'(plan_empty_o));
        check_field("last_move", DATA_W'(want_mv.last), DATA_W'(last_move_o));
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cyc <= 0;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
      if (quiet_cyc >= STALL_LIMIT) begin
        $display("greedy_load_rebalance_planner: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Load channel helpers
  // --------------------------------------------------------------------------
  task automatic send_load(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] cnt,
                           input logic last);
    // idle cycles carry junk payload that must be ignored
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i     <= 1'b0;
      worker_id_i    <= ID_W'($urandom());
      object_count_i <= $urandom();
      last_worker_i  <= 1'($urandom());
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    worker_id_i    <= id;
    object_count_i <= cnt;
    last_worker_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    load_count(id, cnt, last);
  endtask

  // Hold off loads until every planned move has come out
  task automatic wait_plan_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_moves.size() != 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_count(spread_e spread);
    case (spread)
      SPREAD_SMALL: return DATA_W'($urandom_range(0, 20));
      SPREAD_FULL:  return $urandom();
      SPREAD_TOP:   return 32'hFFFF_FFFF - DATA_W'($urandom_range(0, 20));
      default:      return pick_count(spread_e'($urandom_range(0, 2)));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One worker alone is already balanced
  task automatic test_single_worker();
    send_load(4'd0, 32'd0, 1'b1);
  endtask

  // Equal counts at the top of the range give an empty plan
  task automatic test_balanced_extremes();
    send_load(4'd3, 32'hFFFF_FFFF, 1'b0);
    send_load(4'd7, 32'hFFFF_FFFF, 1'b1);
  endtask

  // A repeated id replaces the earlier count
  task automatic test_overwrite();
    send_load(4'd5, 32'd100, 1'b0);
    send_load(4'd5, 32'hFFFF_FFFF, 1'b0);
    send_load(4'd9, 32'd0, 1'b1);
  endtask

  // Every id present, alternating empty and full; sum needs the wide adder
  task automatic test_full_table();
    for (int i = 0; i < NWORK; i++) begin
      send_load(ID_W'(i), (i % 2 == 0) ? 32'd0 : 32'hFFFF_FFFF, i == NWORK - 1);
    end
    wait_plan_drained();
  endtask

  task automatic run_random_sets(input int unsigned n_items, input int unsigned idle_pct,
                                 input int unsigned stall);
    int unsigned sent;
    int unsigned set_len;
    spread_e     spread;
    sent         = 0;
    src_idle_pct = idle_pct;
    stall_pct    = stall;
    while (sent < n_items) begin
      // mostly short sets, now and then a long one with many repeated ids
      set_len = ($urandom_range(0, 8) == 0) ? $urandom_range(10, 20)
                                            : $urandom_range(1, 6);
      spread  = spread_e'($urandom_range(0, 3));
      for (int k = 0; k < set_len; k++) begin
        send_load(ID_W'($urandom_range(0, NWORK - 1)), pick_count(spread),
                  k == set_len - 1);
      end
      sent += set_len;
      if ($urandom_range(0, 3) == 0) wait_plan_drained();
    end
  endtask

  task automatic test_random_no_idle();
    run_random_sets(48, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random_sets(48, 61, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random_sets(48, 0, 61);
  endtask

  task automatic test_random_both_idle();
    run_random_sets(48, 29, 29);
  endtask

  initial begin
    fail_cnt     = 0;
    src_idle_pct = 0;
    stall_pct    = 0;
    tally        = '0;
    n_loaded     = 0;
    foreach (seen[i]) begin
      seen[i]    = 1'b0;
      cnt_tbl[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_worker();
    test_balanced_extremes();
    test_overwrite();
    test_full_table();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    // drain, then give the block time for any stray transfer
    wait_plan_drained();
    repeat (64) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("greedy_load_rebalance_planner: match");
    end else begin
      $display("greedy_load_rebalance_planner: mismatch");
    end
    $finish;
  end

endmodule
